// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== hdl/dps_pkg.sv =====
// Package for the decimal power scaler: types, ROM tables, codes.
// No dependencies.
package dps_pkg;
  localparam int DEC_EXP_BITS_DEF = 14;
  localparam int BIN_EXP_BITS = 16;
  localparam int ROM_DEPTH = 80;
  localparam int ROM_IDX_BITS = 7;
  localparam int IDX_POS_SMALL = 0;
  localparam int IDX_POS_BIG = 31;
  localparam int IDX_NEG_SMALL = 40;
  localparam int IDX_NEG_BIG = 71;
  localparam int BIG_CHUNK_MAX = 9;

  typedef struct packed {
    logic start;
    logic [ROM_IDX_BITS-1:0] idx;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic logic [127:0] rom_frac(input logic [ROM_IDX_BITS-1:0] k);
    logic [127:0] r;
    r = '0;
    case (k)
      7'd0: r = 128'ha0000000000000000000000000000000;
      7'd1: r = 128'hc8000000000000000000000000000000;
      7'd2: r = 128'hfa000000000000000000000000000000;
      7'd3: r = 128'h9c400000000000000000000000000000;
      7'd4: r = 128'hc3500000000000000000000000000000;
      7'd5: r = 128'hf4240000000000000000000000000000;
      7'd6: r = 128'h98968000000000000000000000000000;
      7'd7: r = 128'hbebc2000000000000000000000000000;
      7'd8: r = 128'hee6b2800000000000000000000000000;
      7'd9: r = 128'h9502f900000000000000000000000000;
      7'd10: r = 128'hba43b740000000000000000000000000;
      7'd11: r = 128'he8d4a510000000000000000000000000;
      7'd12: r = 128'h9184e72a000000000000000000000000;
      7'd13: r = 128'hb5e620f4800000000000000000000000;
      7'd14: r = 128'he35fa931a00000000000000000000000;
      7'd15: r = 128'h8e1bc9bf040000000000000000000000;
      7'd16: r = 128'hb1a2bc2ec50000000000000000000000;
      7'd17: r = 128'hde0b6b3a764000000000000000000000;
      7'd18: r = 128'h8ac7230489e800000000000000000000;
      7'd19: r = 128'had78ebc5ac6200000000000000000000;
      7'd20: r = 128'hd8d726b7177a80000000000000000000;
      7'd21: r = 128'h878678326eac90000000000000000000;
      7'd22: r = 128'ha968163f0a57b4000000000000000000;
      7'd23: r = 128'hd3c21bcecceda1000000000000000000;
      7'd24: r = 128'h84595161401484a00000000000000000;
      7'd25: r = 128'ha56fa5b99019a5c80000000000000000;
      7'd26: r = 128'hcecb8f27f4200f3a0000000000000000;
      7'd27: r = 128'h813f3978f89409844000000000000000;
      7'd28: r = 128'ha18f07d736b90be55000000000000000;
      7'd29: r = 128'hc9f2c9cd04674edea400000000000000;
      7'd30: r = 128'hfc6f7c40458122964d00000000000000;
      7'd31: r = 128'h9dc5ada82b70b59df020000000000000;
      7'd32: r = 128'hc2781f49ffcfa6d53cbf6b71c76b25fb;
      7'd33: r = 128'hefb3ab16c59b14a2c5cfe94ef3ea101e;
      7'd34: r = 128'h93ba47c980e98cdfc66f336c36b10137;
      7'd35: r = 128'hb616a12b7fe617aa577b986b314d6009;
      7'd36: r = 128'he070f78d3927556a85bbe253f47b1417;
      7'd37: r = 128'h8a5296ffe33cc92f82bd6b70d99aaa70;
      7'd38: r = 128'haa7eebfb9df9de8dddbb901b98feeab8;
      7'd39: r = 128'hd226fc195c6a2f8c73832eec6fff3112;
      7'd40: r = 128'hcccccccccccccccccccccccccccccccd;
      7'd41: r = 128'ha3d70a3d70a3d70a3d70a3d70a3d70a4;
      7'd42: r = 128'h83126e978d4fdf3b645a1cac083126e9;
      7'd43: r = 128'hd1b71758e219652bd3c36113404ea4a9;
      7'd44: r = 128'ha7c5ac471b4784230fcf80dc33721d54;
      7'd45: r = 128'h8637bd05af6c69b5a63f9a49c2c1b110;
      7'd46: r = 128'hd6bf94d5e57a42bc3d32907604691b4d;
      7'd47: r = 128'habcc77118461cefcfdc20d2b36ba7c3d;
      7'd48: r = 128'h89705f4136b4a59731680a88f8953031;
      7'd49: r = 128'hdbe6fecebdedd5beb573440e5a884d1b;
      7'd50: r = 128'hafebff0bcb24aafef78f69a51539d749;
      7'd51: r = 128'h8cbccc096f5088cbf93f87b7442e45d4;
      7'd52: r = 128'he12e13424bb40e132865a5f206b06fba;
      7'd53: r = 128'hb424dc35095cd80f538484c19ef38c94;
      7'd54: r = 128'h901d7cf73ab0acd90f9d37014bf60a10;
      7'd55: r = 128'he69594bec44de15b4c2ebe687989a9b4;
      7'd56: r = 128'hb877aa3236a4b44909befeb9fad487c3;
      7'd57: r = 128'h9392ee8e921d5d073aff322e62439fcf;
      7'd58: r = 128'hec1e4a7db69561a52b31e9e3d06c32e5;
      7'd59: r = 128'hbce5086492111aea88f4bb1ca6bcf584;
      7'd60: r = 128'h971da05074da7beed3f6fc16ebca5e03;
      7'd61: r = 128'hf1c90080baf72cb15324c68b12dd6338;
      7'd62: r = 128'hc16d9a0095928a2775b7053c0f178294;
      7'd63: r = 128'h9abe14cd44753b52c4926a9672793543;
      7'd64: r = 128'hf79687aed3eec5513a83ddbd83f52205;
      7'd65: r = 128'hc612062576589dda95364afe032a819d;
      7'd66: r = 128'h9e74d1b791e07e48775ea264cf55347e;
      7'd67: r = 128'hfd87b5f28300ca0d8bca9d6e188853fc;
      7'd68: r = 128'hcad2f7f5359a3b3e096ee45813a04330;
      7'd69: r = 128'ha2425ff75e14fc31a1258379a94d028d;
      7'd70: r = 128'h81ceb32c4b43fcf480eacf948770ced7;
      7'd71: r = 128'hcfb11ead453994ba67de18eda5814af2;
      7'd72: r = 128'ha87fea27a539e9a53f2398d747b36224;
      7'd73: r = 128'h88b402f7fd75539b11dbcb0218ebb414;
      7'd74: r = 128'hddd0467c64bce4a0ac7cb3f6d05ddbdf;
      7'd75: r = 128'hb3f4e093db73a09359ed216765690f57;
      7'd76: r = 128'h91ff83775423cc067b6306a34627ddcf;
      7'd77: r = 128'hece53cec4a314ebda4f8bf5635246428;
      7'd78: r = 128'hc0314325637a1939fa911155fefb5309;
      7'd79: r = 128'h9becce62836ac5774ee367f9430aec33;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [11:0] rom_bexp(input logic [ROM_IDX_BITS-1:0] k);
    logic signed [11:0] r;
    r = '0;
    case (k)
      7'd0: r = 12'sd4;    7'd1: r = 12'sd7;    7'd2: r = 12'sd10;   7'd3: r = 12'sd14;
      7'd4: r = 12'sd17;   7'd5: r = 12'sd20;   7'd6: r = 12'sd24;   7'd7: r = 12'sd27;
      7'd8: r = 12'sd30;   7'd9: r = 12'sd34;   7'd10: r = 12'sd37;  7'd11: r = 12'sd40;
      7'd12: r = 12'sd44;  7'd13: r = 12'sd47;  7'd14: r = 12'sd50;  7'd15: r = 12'sd54;
      7'd16: r = 12'sd57;  7'd17: r = 12'sd60;  7'd18: r = 12'sd64;  7'd19: r = 12'sd67;
      7'd20: r = 12'sd70;  7'd21: r = 12'sd74;  7'd22: r = 12'sd77;  7'd23: r = 12'sd80;
      7'd24: r = 12'sd84;  7'd25: r = 12'sd87;  7'd26: r = 12'sd90;  7'd27: r = 12'sd94;
      7'd28: r = 12'sd97;  7'd29: r = 12'sd100; 7'd30: r = 12'sd103; 7'd31: r = 12'sd107;
      7'd32: r = 12'sd213; 7'd33: r = 12'sd319; 7'd34: r = 12'sd426; 7'd35: r = 12'sd532;
      7'd36: r = 12'sd638; 7'd37: r = 12'sd745; 7'd38: r = 12'sd851; 7'd39: r = 12'sd957;
      7'd40: r = -12'sd3;   7'd41: r = -12'sd6;   7'd42: r = -12'sd9;   7'd43: r = -12'sd13;
      7'd44: r = -12'sd16;  7'd45: r = -12'sd19;  7'd46: r = -12'sd23;  7'd47: r = -12'sd26;
      7'd48: r = -12'sd29;  7'd49: r = -12'sd33;  7'd50: r = -12'sd36;  7'd51: r = -12'sd39;
      7'd52: r = -12'sd43;  7'd53: r = -12'sd46;  7'd54: r = -12'sd49;  7'd55: r = -12'sd53;
      7'd56: r = -12'sd56;  7'd57: r = -12'sd59;  7'd58: r = -12'sd63;  7'd59: r = -12'sd66;
      7'd60: r = -12'sd69;  7'd61: r = -12'sd73;  7'd62: r = -12'sd76;  7'd63: r = -12'sd79;
      7'd64: r = -12'sd83;  7'd65: r = -12'sd86;  7'd66: r = -12'sd89;  7'd67: r = -12'sd93;
      7'd68: r = -12'sd96;  7'd69: r = -12'sd99;  7'd70: r = -12'sd102; 7'd71: r = -12'sd106;
      7'd72: r = -12'sd212; 7'd73: r = -12'sd318; 7'd74: r = -12'sd425; 7'd75: r = -12'sd531;
      7'd76: r = -12'sd637; 7'd77: r = -12'sd744; 7'd78: r = -12'sd850; 7'd79: r = -12'sd956;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== hdl/dps_if.sv =====
// Valid/ready channel interfaces for the decimal power scaler.
// Depends on nothing.
interface dps_in_if #(parameter int DEC_EXP_BITS = 14);
  logic valid;
  logic ready;
  logic [63:0] frac_hi;
  logic [63:0] frac_lo;
  logic signed [DEC_EXP_BITS-1:0] dec_exp;
  modport source (output valid, frac_hi, frac_lo, dec_exp, input ready);
  modport sink (input valid, frac_hi, frac_lo, dec_exp, output ready);
endinterface

interface dps_out_if;
  logic valid;
  logic ready;
  logic [63:0] res_hi;
  logic [63:0] res_lo;
  logic signed [15:0] bin_exp;
  modport source (output valid, res_hi, res_lo, bin_exp, input ready);
  modport sink (input valid, res_hi, res_lo, bin_exp, output ready);
endinterface

// ===== hdl/decimal_power_scale_128.sv =====
// Top level of the decimal power scaler: controller plus datapath.
// Depends on dps_pkg, dps_if, dps_ctrl, dps_datapath.
// One item at a time. Each ROM step applies one chunk of at most nine big
// powers or the one small power, so a 14-bit exponent needs up to 30 steps
// (29 big chunks plus one small). Each step is a 128x128 product built from
// 16 partial products on one 32x32 multiplier; a zero exponent skips the
// multiply steps.
module decimal_power_scale_128 #(
  parameter int DEC_EXP_BITS = dps_pkg::DEC_EXP_BITS_DEF
) (
  input logic clk,
  input logic rst,
  dps_in_if.sink in_ch,
  dps_out_if.source out_ch
);
  import dps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [127:0] frac;
  logic signed [BIN_EXP_BITS-1:0] bexp;

  dps_ctrl #(.DEC_EXP_BITS(DEC_EXP_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .dec_exp(in_ch.dec_exp),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  dps_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .frac_in({in_ch.frac_hi, in_ch.frac_lo}), .frac(frac), .bexp(bexp)
  );

  assign out_ch.res_hi = frac[127:64];
  assign out_ch.res_lo = frac[63:0];
  assign out_ch.bin_exp = bexp;
endmodule

// ===== hdl/dps_datapath.sv =====
// Datapath: fraction register, shared 32x32 multiplier, 256-bit accumulator,
// normalize and round. Depends on dps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dps_datapath (
  input  logic clk,
  input  logic rst,
  input  dps_pkg::dp_cmd_t cmd,
  output dps_pkg::dp_sts_t sts,
  input  logic [127:0] frac_in,
  output logic [127:0] frac,
  output logic signed [dps_pkg::BIN_EXP_BITS-1:0] bexp
);
  import dps_pkg::*;

  logic [127:0] y;
  logic [255:0] acc;
  logic [4:0] pp;
  logic busy;
  logic mvalid;
  logic [63:0] mprod;
  logic [3:0] mi;
  logic [3:0] mj;
  logic [ROM_IDX_BITS-1:0] idx;
  logic [1:0] ai;
  logic [1:0] bj;
  logic [31:0] aw;
  logic [31:0] bw;
  logic [7:0] shamt;
  logic [255:0] addend;
  logic [255:0] w;
  logic [127:0] nf;
  logic is_half;
  logic rnd;
  logic [127:0] rf;
  logic signed [BIN_EXP_BITS-1:0] step_exp;

  assign ai = pp[3:2];
  assign bj = pp[1:0];
  always_comb begin
    aw = frac[32*ai +: 32];
    bw = y[32*bj +: 32];
  end
  assign shamt = {({1'b0, mi[3:2]} + {1'b0, mi[1:0]}), 5'd0};
  assign addend = {192'd0, mprod} << shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mvalid <= 1'b0;
      pp <= '0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      mvalid <= busy && !pp[4];
      if (cmd.start) begin
        busy <= 1'b1;
        pp <= '0;
      end else if (busy) begin
        if (!pp[4]) pp <= pp + 5'd1;
        else if (!mvalid) begin
          busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mprod <= aw * bw;
    mi <= pp[3:0];
    mj <= pp[3:0];
    if (cmd.start) begin
      y <= rom_frac(cmd.idx);
      idx <= cmd.idx;
      acc <= '0;
    end else if (mvalid) begin
      acc <= acc + addend;
    end
    if (cmd.load) begin
      frac <= frac_in;
      bexp <= '0;
    end else if (busy && pp[4] && !mvalid) begin
      frac <= rf;
      bexp <= bexp + step_exp;
    end
  end

  always_comb begin
    w = acc;
    is_half = 1'b0;
    nf = w[255:128];
    step_exp = BIN_EXP_BITS'(rom_bexp(idx));
    if (!w[255]) begin
      is_half = (w[255:128] == {1'b0, {127{1'b1}}}) && (w[127:126] == 2'b11);
      nf = w[254:127];
      step_exp = BIN_EXP_BITS'(rom_bexp(idx)) - 16'sd1;
    end
    rnd = (w[255] ? w[127] : w[126]) &&
          (nf[0] || (w[255] ? (w[126:0] != '0) : (w[125:0] != '0)));
    rf = nf + {127'd0, rnd};
    if (is_half) begin
      rf = {1'b1, 127'd0};
      step_exp = BIN_EXP_BITS'(rom_bexp(idx));
    end
  end

  `CHK_NEXT(a_start_busy, clk, rst, cmd.start, busy)
  `CHK_IMPL(a_done_idle, clk, rst, sts.done, !mvalid)
  `CHK_NEXT(a_mi_track, clk, rst, busy && !pp[4], mvalid && mj == mi)
endmodule

// ===== hdl/dps_ctrl.sv =====
// Controller: splits the decimal exponent into ROM steps, runs handshakes.
// Depends on dps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dps_ctrl #(
  parameter int DEC_EXP_BITS = dps_pkg::DEC_EXP_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [DEC_EXP_BITS-1:0] dec_exp,
  output logic out_valid,
  input  logic out_ready,
  output dps_pkg::dp_cmd_t cmd,
  input  dps_pkg::dp_sts_t sts
);
  import dps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT = 4'b1000
  } state_t;

  localparam int CB = DEC_EXP_BITS - 5;
  state_t state;
  logic neg;
  logic [CB-1:0] chunks;
  logic [4:0] rest;
  logic [DEC_EXP_BITS-1:0] mag;
  logic [CB-1:0] c;
  logic [ROM_IDX_BITS-1:0] idx;

  assign mag = dec_exp[DEC_EXP_BITS-1] ? DEC_EXP_BITS'(-dec_exp) : dec_exp;
  assign c = (chunks < CB'(BIG_CHUNK_MAX)) ? chunks : CB'(BIG_CHUNK_MAX);
  always_comb begin
    if (chunks != '0)
      idx = ROM_IDX_BITS'(neg ? IDX_NEG_BIG : IDX_POS_BIG) + ROM_IDX_BITS'(c) - 7'd1;
    else
      idx = ROM_IDX_BITS'(neg ? IDX_NEG_SMALL : IDX_POS_SMALL) + {2'b0, rest} - 7'd1;
  end

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign cmd.load = in_valid && in_ready;
  assign cmd.start = state == S_ISSUE;
  assign cmd.idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          neg <= dec_exp[DEC_EXP_BITS-1];
          chunks <= mag[DEC_EXP_BITS-1:5];
          rest <= mag[4:0];
          state <= (mag == '0) ? S_OUT : S_ISSUE;
        end
        S_ISSUE: begin
          if (chunks != '0) chunks <= chunks - c;
          else rest <= '0;
          state <= S_WAIT;
        end
        S_WAIT: if (sts.done) begin
          state <= (chunks == '0 && rest == '0) ? S_OUT : S_ISSUE;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_no_start_idle, clk, rst, cmd.start, state != S_IDLE)
  `CHK_IMPL(a_done_in_wait, clk, rst, sts.done, state == S_WAIT)
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

// ===== tb/tb.sv =====
// Testbench for decimal_power_scale_128: drives (fraction, decimal exponent) beats,
// predicts the scaled fraction and binary exponent, and checks every result beat.
// Depends on dps_pkg, dps_if and the RTL top level.
`timescale 1ns / 100ps
module tb;
  import dps_pkg::*;

  localparam int EXP_W = DEC_EXP_BITS_DEF;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [EXP_W-1:0] dexp;
  } scale_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] bexp;
  } scaled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;
  bit all_sent = 1'b0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  scale_req_t req_q[$];
  scaled_t scaled_q[$];

  dps_in_if #(.DEC_EXP_BITS(EXP_W)) in_ch();
  dps_out_if out_ch();

  decimal_power_scale_128 #(.DEC_EXP_BITS(EXP_W)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one multiply by a power-of-ten fraction, normalize by up to one bit, round to even
  function automatic int mul_pow10(ref logic [127:0] f, input int k);
    logic [255:0] w;
    logic [127:0] c;
    logic [127:0] tail;
    int sh;
    c = rom_frac(k[ROM_IDX_BITS-1:0]);
    w = {128'b0, f} * {128'b0, c};
    sh = 0;
    if (!w[255]) begin
      if (w[254:126] == {129{1'b1}}) begin
        f = {1'b1, 127'b0};
        return int'(rom_bexp(k[ROM_IDX_BITS-1:0]));
      end
      w = w << 1;
      sh = 1;
    end
    f = w[255:128];
    tail = w[127:0];
    if (tail[127] && (f[0] || tail[126:0] != '0)) f = f + 1;
    return int'(rom_bexp(k[ROM_IDX_BITS-1:0])) - sh;
  endfunction

  function automatic scaled_t scale_by_pow10(scale_req_t r);
    logic [127:0] f;
    int e, mag, chunks, rest, c, bexp, sb, bb;
    scaled_t o;
    f = {r.hi, r.lo};
    e = $signed(r.dexp);
    bexp = 0;
    if (e != 0) begin
      mag = e > 0 ? e : -e;
      sb = e > 0 ? IDX_POS_SMALL : IDX_NEG_SMALL;
      bb = e > 0 ? IDX_POS_BIG : IDX_NEG_BIG;
      chunks = mag >> 5;
      rest = mag & 31;
      while (chunks != 0) begin
        c = chunks < BIG_CHUNK_MAX ? chunks : BIG_CHUNK_MAX;
        chunks -= c;
        bexp += mul_pow10(f, bb + c - 1);
      end
      if (rest != 0) bexp += mul_pow10(f, sb + rest - 1);
    end
    o.hi = f[127:64];
    o.lo = f[63:0];
    o.bexp = bexp[15:0];
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_req(logic [63:0] hi, logic [63:0] lo, int e);
    scale_req_t r;
    r.hi = hi;
    r.lo = lo;
    r.dexp = e[EXP_W-1:0];
    req_q.push_back(r);
  endtask

  initial begin
    int e;
    logic [63:0] hi;
    add_req(64'h8000_0000_0000_0000, 64'h0, 0);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    add_req(64'h8000_0000_0000_0000, 64'h0, -1);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, -1);
    add_req(64'hC000_0000_0000_0000, 64'h1, 8191);
    add_req(64'h8000_0000_0000_0000, 64'h0, -8192);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8191);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, -8192);
    add_req(64'h9000_0000_0000_0000, 64'h0, 31);
    add_req(64'h9000_0000_0000_0000, 64'h0, -31);
    add_req(64'hA000_0000_0000_0000, 64'h0, 32);
    add_req(64'hA000_0000_0000_0000, 64'h0, -32);
    add_req(64'hB000_0000_0000_0000, 64'h5, 288);
    add_req(64'hB000_0000_0000_0000, 64'h5, -288);
    add_req(64'hD000_0000_0000_0000, 64'h0, 320);
    add_req(64'hCCCC_CCCC_CCCC_CCCC, 64'hCCCC_CCCC_CCCC_CCCD, 1);
    add_req(64'h8000_0000_0000_0000, 64'h0, 1);
    add_req(64'h0, 64'h0, 100);
    add_req(64'h0, 64'h1, -5);
    add_req(64'h1234_5678_9ABC_DEF0, 64'h0, 7);
    for (int i = 0; i < 1150; i++) begin
      case ($urandom_range(9))
        0: e = $urandom_range(63) - 31;
        1: e = $urandom_range(8191);
        2: e = -int'($urandom_range(8192));
        3: e = ($urandom_range(1) ? 1 : -1) * (32 * int'($urandom_range(1, 20)));
        default: e = $urandom_range(1500) - 750;
      endcase
      hi = rand64();
      if ($urandom_range(19) != 0) hi[63] = 1'b1;
      add_req(hi, rand64(), e);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.frac_hi <= '0;
      in_ch.frac_lo <= '0;
      in_ch.dec_exp <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) scaled_q.push_back(scale_by_pow10(
          {in_ch.frac_hi, in_ch.frac_lo, in_ch.dec_exp}));
      if (!in_ch.valid || in_ch.ready) begin
        if (req_q.size() != 0 && (quiet_in || $urandom_range(99) >= 15)) begin
          scale_req_t r;
          r = req_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.frac_hi <= r.hi;
          in_ch.frac_lo <= r.lo;
          in_ch.dec_exp <= r.dexp;
        end else begin
          in_ch.valid <= 1'b0;
          if (req_q.size() == 0) all_sent <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_out || $urandom_range(99) >= 15;
      if (out_ch.valid && out_ch.ready) begin
        if (scaled_q.size() == 0) begin
          $display("%0t: unexpected result %h %h %h", $time,
                   out_ch.res_hi, out_ch.res_lo, out_ch.bin_exp);
          failed <= 1'b1;
        end else begin
          scaled_t x;
          x = scaled_q.pop_front();
          if (x.hi !== out_ch.res_hi || x.lo !== out_ch.res_lo ||
              x.bexp !== out_ch.bin_exp) begin
            $display("%0t: mismatch expected %h %h %h actual %h %h %h", $time,
                     x.hi, x.lo, x.bexp, out_ch.res_hi, out_ch.res_lo, out_ch.bin_exp);
            failed <= 1'b1;
          end
        end
      end
    end
  end

  // stretch with no idling on either side
  initial begin
    #30000;
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    #60000;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  end

  initial begin
    wait (all_sent && !in_ch.valid && scaled_q.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("decimal_power_scale_128 verification clean");
    end else begin
      $display("decimal_power_scale_128 verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("decimal_power_scale_128 verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/dps_pkg.sv
hdl/dps_if.sv
hdl/dps_datapath.sv
hdl/dps_ctrl.sv
hdl/decimal_power_scale_128.sv
tb/tb.sv
